// ===== rtl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants for the fan drive start/stop sequencer.
// ----------------------------------------------------------------------------
package vfd_pkg;

    // input item
    typedef struct packed {
        logic        tick;
        logic        enable_request;
        logic        drive_fault;
        logic [11:0] motor_temp;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        fan_ok;
        logic        supply_enable;
        logic        drive_start;
        logic [1:0]  error_code;
        logic [2:0]  phase;
    } t_out_item;

    // configuration port widths
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 12;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MOTOR_TEMP   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_DELAY_S   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_DELAY_S    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 8'd3;

    // register reset values
    localparam logic [11:0] RST_MAX_MOTOR_TEMP   = 12'd4095;
    localparam logic [7:0]  RST_ENABLE_DELAY_S   = 8'd5;
    localparam logic [7:0]  RST_DECEL_DELAY_S    = 8'd20;
    localparam logic [7:0]  RST_TICKS_PER_SECOND = 8'd30;

    // sequencer phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_SUPPLY_ON  = 3'd1;
    localparam logic [2:0] PH_TEMP_CHECK = 3'd2;
    localparam logic [2:0] PH_ENABLE_WT  = 3'd3;
    localparam logic [2:0] PH_RUNNING    = 3'd4;
    localparam logic [2:0] PH_STOP       = 3'd5;
    localparam logic [2:0] PH_DECEL_WT   = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERTEMP = 2'd1;
    localparam logic [1:0] ERR_FAULT    = 2'd2;

endpackage

// ===== rtl/vfd_start_stop_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// vfd_start_stop_sequencer_core
// Start/stop sequencer for a variable-frequency fan drive.
// ----------------------------------------------------------------------------
// Use: each input item (i_valid, i_item) carries a prescaler tick flag, the
// run request, the drive fault flag and the motor temperature. Every accepted
// item produces exactly one result item (o_valid, o_item) with the ok latch,
// supply and drive commands, held error code and the phase after the step.
// The result is registered: it is loaded into the output register at the
// accepting edge and can be taken at the next edge. Throughput is one item
// per cycle while o_stall is low, set by the single sequencer state update.
// When the receiver holds i_stall while a result waits, o_stall rises and
// no further item is accepted until that result is taken; while the output
// register is empty or being drained, items are taken every cycle.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) is always ready; unknown indexes are ignored.
// Synchronous reset returns config and state registers to their defaults,
// the sequencer to idle with the ok latch set, and empties the output register.
// ----------------------------------------------------------------------------
module vfd_start_stop_sequencer_core
    import vfd_pkg::*;
#(
    parameter int SECONDS_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in_item               i_item,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_item              o_item,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [SECONDS_WIDTH-1:0] SEC_MAX = '1;
    localparam logic [SECONDS_WIDTH-1:0] SEC_ONE = SECONDS_WIDTH'(1);

    // configuration registers
    logic [11:0] r_max_motor_temp;
    logic [7:0]  r_enable_delay_s;
    logic [7:0]  r_decel_delay_s;
    logic [7:0]  r_ticks_per_second;

    // sequencer state
    logic [7:0]               r_tick_count, n_tick_count;
    logic [SECONDS_WIDTH-1:0] r_seconds, n_seconds;
    logic [SECONDS_WIDTH-1:0] r_deadline, n_deadline;
    logic [2:0]               r_phase, n_phase;
    logic                     r_ok_latch, n_ok_latch;
    logic                     r_supply_on, n_supply_on;
    logic                     r_start_on, n_start_on;
    logic [1:0]               r_error, n_error;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic                     in_accept;
    logic                     hot;
    logic                     cool;
    logic [7:0]               tick_inc;
    logic [SECONDS_WIDTH-1:0] sec_ticked;
    logic [7:0]               cap_delay;
    logic [SECONDS_WIDTH-1:0] cap_delay_ext;
    logic [SECONDS_WIDTH-1:0] cap_limit;
    logic [SECONDS_WIDTH-1:0] cap_base;
    logic                     deadline_hit;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign in_accept   = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_motor_temp   <= RST_MAX_MOTOR_TEMP;
            r_enable_delay_s   <= RST_ENABLE_DELAY_S;
            r_decel_delay_s    <= RST_DECEL_DELAY_S;
            r_ticks_per_second <= RST_TICKS_PER_SECOND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_MOTOR_TEMP:   r_max_motor_temp   <= i_cfg_data;
                REG_ENABLE_DELAY_S:   r_enable_delay_s   <= i_cfg_data[7:0];
                REG_DECEL_DELAY_S:    r_decel_delay_s    <= i_cfg_data[7:0];
                REG_TICKS_PER_SECOND: r_ticks_per_second <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // temperature compares
    assign hot  = i_item.motor_temp > r_max_motor_temp;
    assign cool = i_item.motor_temp < r_max_motor_temp;

    // tick prescaler and seconds counter
    assign tick_inc = r_tick_count + 8'd1;
    always_comb begin
        n_tick_count = r_tick_count;
        sec_ticked   = r_seconds;
        if (i_item.tick) begin
            if (tick_inc >= r_ticks_per_second) begin
                n_tick_count = 8'd0;
                sec_ticked   = r_seconds + SEC_ONE;
            end else begin
                n_tick_count = tick_inc;
            end
        end
    end

    // deadline capture, shared by the supply-on and stop phases
    assign cap_delay     = (r_phase == PH_STOP) ? r_decel_delay_s : r_enable_delay_s;
    assign cap_delay_ext = {{(SECONDS_WIDTH-8){1'b0}}, cap_delay};
    assign cap_limit     = SEC_MAX - cap_delay_ext - SEC_ONE;
    assign cap_base      = (sec_ticked > cap_limit) ? '0 : sec_ticked;
    assign deadline_hit  = sec_ticked >= r_deadline;

    // sequencer step
    always_comb begin
        n_seconds   = sec_ticked;
        n_deadline  = r_deadline;
        n_phase     = r_phase;
        n_ok_latch  = r_ok_latch;
        n_supply_on = r_supply_on;
        n_start_on  = r_start_on;
        n_error     = r_error;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.enable_request && cool && r_ok_latch && !i_item.drive_fault) begin
                    n_phase = PH_SUPPLY_ON;
                    n_error = ERR_NONE;
                end
                if (!i_item.enable_request && cool && !r_ok_latch && !i_item.drive_fault) begin
                    n_ok_latch = 1'b1;
                    n_error    = ERR_NONE;
                end
                if (hot) begin
                    n_error = ERR_OVERTEMP;
                end
            end
            PH_SUPPLY_ON: begin
                n_supply_on = 1'b1;
                n_seconds   = cap_base;
                n_deadline  = cap_base + cap_delay_ext;
                n_phase     = PH_TEMP_CHECK;
            end
            PH_TEMP_CHECK: begin
                if (hot) begin
                    n_error     = ERR_OVERTEMP;
                    n_ok_latch  = 1'b0;
                    n_supply_on = 1'b0;
                    n_phase     = PH_IDLE;
                end else begin
                    n_phase = PH_ENABLE_WT;
                end
            end
            PH_ENABLE_WT: begin
                if (deadline_hit) begin
                    n_start_on = 1'b1;
                    n_phase    = PH_RUNNING;
                end
            end
            PH_RUNNING: begin
                if (!i_item.enable_request) begin
                    n_phase = PH_STOP;
                end else if (hot) begin
                    n_error    = ERR_OVERTEMP;
                    n_ok_latch = 1'b0;
                    n_phase    = PH_STOP;
                end else if (i_item.drive_fault) begin
                    n_error    = ERR_FAULT;
                    n_ok_latch = 1'b0;
                    n_phase    = PH_STOP;
                end
            end
            PH_STOP: begin
                n_start_on = 1'b0;
                n_seconds  = cap_base;
                n_deadline = cap_base + cap_delay_ext;
                n_phase    = PH_DECEL_WT;
            end
            PH_DECEL_WT: begin
                if (deadline_hit) begin
                    n_supply_on = 1'b0;
                    n_phase     = PH_IDLE;
                end
            end
            default: begin
                // unused phase code falls back to idle with everything off
                n_supply_on = 1'b0;
                n_start_on  = 1'b0;
                n_phase     = PH_IDLE;
            end
        endcase
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= 8'd0;
            r_seconds    <= '0;
            r_deadline   <= '0;
            r_phase      <= PH_IDLE;
            r_ok_latch   <= 1'b1;
            r_supply_on  <= 1'b0;
            r_start_on   <= 1'b0;
            r_error      <= ERR_NONE;
        end else if (in_accept) begin
            r_tick_count <= n_tick_count;
            r_seconds    <= n_seconds;
            r_deadline   <= n_deadline;
            r_phase      <= n_phase;
            r_ok_latch   <= n_ok_latch;
            r_supply_on  <= n_supply_on;
            r_start_on   <= n_start_on;
            r_error      <= n_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out.fan_ok        <= n_ok_latch;
            r_out.supply_enable <= n_supply_on;
            r_out.drive_start   <= n_start_on;
            r_out.error_code    <= n_error;
            r_out.phase         <= n_phase;
        end
    end

endmodule
